### hw/rtl/vector_distance_similarity_core_macros.svh
// Assertion macros for the vector distance and similarity core.
`ifndef VECTOR_DISTANCE_SIMILARITY_CORE_MACROS_SVH
`define VECTOR_DISTANCE_SIMILARITY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("vds: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VDS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("vds: next-cycle assertion failed");

`endif

### hw/rtl/vds_pkg.sv
// Package with constants, types and helper functions of the vector distance core.
`timescale 1ns / 1ps

package vds_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int ACC_WIDTH  = 48;
  localparam int VALUE_W    = 48;
  localparam int MODE_W     = 2;
  localparam int MAG_W      = ELEM_WIDTH + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SUM_W      = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;
  localparam int HALF_W     = ACC_WIDTH / 2;
  localparam int PAIR_W     = 2 * ACC_WIDTH;
  localparam int COS_QW     = 15;
  localparam int BIT_W      = $clog2(COS_QW);
  localparam int SH_W       = $clog2(2 * COS_QW);
  localparam int BIG_W      = PAIR_W + 2 * COS_QW + 1;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] IDX_LAST = '1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_L2H = 2'd0,
    MODE_L1  = 2'd1,
    MODE_DOT = 2'd2,
    MODE_COS = 2'd3
  } vds_mode_t;

  typedef enum logic [1:0] {
    ST_ACC   = 2'd0,
    ST_DRAIN = 2'd1,
    ST_FIN   = 2'd2,
    ST_COS   = 2'd3
  } vds_state_t;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'd0,
    CS_MUL   = 3'd1,
    CS_DRAIN = 3'd2,
    CS_CAND  = 3'd3,
    CS_CMP   = 3'd4
  } vds_cos_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic cos_start;
    logic load_direct;
    logic load_cos;
  } vds_cmd_t;

  typedef struct packed {
    logic mode_cos;
    logic cos_busy;
  } vds_sts_t;

  typedef struct packed {
    logic                        sat;
    logic signed [ACC_WIDTH-1:0] val;
  } vds_sat_t;

  // Adds a sign-magnitude term to a signed accumulator, clamping at the range limits.
  function automatic vds_sat_t sat_add(logic signed [ACC_WIDTH-1:0] acc, logic neg,
                                       logic [PROD_W-1:0] mag);
    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] t_ext;
    logic signed [SUM_W-1:0] s;
    vds_sat_t                r;
    a_ext = SUM_W'(acc);
    t_ext = SUM_W'($signed({1'b0, mag}));
    s     = neg ? (a_ext - t_ext) : (a_ext + t_ext);
    if (s > SUM_W'(ACC_MAX)) begin
      r.sat = 1'b1;
      r.val = ACC_MAX;
    end else if (s < SUM_W'(ACC_MIN)) begin
      r.sat = 1'b1;
      r.val = ACC_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = s[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/vector_distance_similarity_core.sv
// Top level of the vector distance and cosine similarity core.
`timescale 1ns / 1ps
// Element pairs (in_x_elem, in_y_elem, signed Q8.8) arrive on the input channel, one item per
// cycle unless stalled, with in_last_elem set on the final pair of a vector. Each vector gives
// one item on the result channel: out_value, and out_overflow set if any running sum saturated.
// cfg_wr_en with cfg_wr_data selects the mode: half squared L2, L1, dot product or cosine.
// Accumulation takes one item per cycle, unless stalled, through a product register and a saturating adder.
// After the final pair the input is stalled until the result sits in the output register;
// for cosine the shared half-width multiplier first makes eight passes, then a candidate and
// a compare step follow for each of the fifteen quotient bits.
// The next vector's items are then accepted while the result waits for the receiver.
// While out_stall is high the result holds; the controller holds back a further result.
// Reset clears the mode to half squared L2, the sums, the saturation flag and the valid flags.

`include "vector_distance_similarity_core_macros.svh"

module vector_distance_similarity_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [vds_pkg::MODE_W-1:0]            cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vds_pkg::ELEM_WIDTH-1:0] in_x_elem,
  input  logic signed [vds_pkg::ELEM_WIDTH-1:0] in_y_elem,
  input  logic                                  in_last_elem,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vds_pkg::VALUE_W-1:0]    out_value,
  output logic                                  out_overflow
);

  vds_pkg::vds_cmd_t cmd;
  vds_pkg::vds_sts_t sts;

  vds_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_elem (in_last_elem),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  vds_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_x_elem    (in_x_elem),
    .in_y_elem    (in_y_elem),
    .out_value    (out_value),
    .out_overflow (out_overflow)
  );

  `VDS_ASSERT_NXT(a_last_item_stalls, clk, rst_n, in_valid && !in_stall && in_last_elem, in_stall)
  `VDS_ASSERT_IMP(a_result_after_stall, clk, rst_n, $rose(out_valid), $past(in_stall))
  `VDS_ASSERT_IMP(a_cos_blocks_input, clk, rst_n, sts.cos_busy, in_stall)

endmodule

### hw/rtl/vds_cos.sv
// Multi-cycle cosine finishing unit: shared partial-product multiplier and bitwise root search.
`timescale 1ns / 1ps

module vds_cos (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [vds_pkg::ACC_WIDTH-1:0]  xy_mag,
  input  logic [vds_pkg::ACC_WIDTH-1:0]  xx_op,
  input  logic [vds_pkg::ACC_WIDTH-1:0]  yy_op,
  output logic                           busy,
  output logic [vds_pkg::COS_QW-1:0]     q
);

  vds_pkg::vds_cos_state_t st_r, st_nxt;

  logic [vds_pkg::ACC_WIDTH-1:0] xy_r, xx_r, yy_r;
  logic [vds_pkg::IDX_W-1:0]     idx_r;
  logic [vds_pkg::ACC_WIDTH-1:0] pp_r;
  logic [1:0]                    pp_sh_r;
  logic                          pp_dst_r;
  logic                          pp_vld_r;
  logic [vds_pkg::PAIR_W-1:0]    prod_p_r, prod_l_r;
  logic [vds_pkg::BIG_W-1:0]     r_r, s_r, cand_r;
  logic [vds_pkg::BIT_W-1:0]     bit_r;
  logic [vds_pkg::COS_QW-1:0]    q_r;

  logic [vds_pkg::ACC_WIDTH-1:0] a_word, b_word;
  logic [vds_pkg::HALF_W-1:0]    a_half, b_half;
  logic [vds_pkg::ACC_WIDTH-1:0] pp_nxt;
  logic [vds_pkg::PAIR_W-1:0]    pp_wide, pp_add;
  logic [vds_pkg::BIG_W-1:0]     p_big, l_big, cand_nxt;
  logic [vds_pkg::SH_W-1:0]      sh_s, sh_p;

  // The first four partial products build xx*yy, the last four build xy*xy.
  assign a_word = idx_r[2] ? xy_r : xx_r;
  assign b_word = idx_r[2] ? xy_r : yy_r;
  assign a_half = idx_r[0] ? a_word[vds_pkg::ACC_WIDTH-1:vds_pkg::HALF_W]
                           : a_word[vds_pkg::HALF_W-1:0];
  assign b_half = idx_r[1] ? b_word[vds_pkg::ACC_WIDTH-1:vds_pkg::HALF_W]
                           : b_word[vds_pkg::HALF_W-1:0];
  assign pp_nxt = vds_pkg::ACC_WIDTH'(a_half) * vds_pkg::ACC_WIDTH'(b_half);

  assign pp_wide = vds_pkg::PAIR_W'(pp_r);
  assign pp_add  = (pp_sh_r == 2'd2) ? (pp_wide << vds_pkg::ACC_WIDTH) :
                   (pp_sh_r == 2'd1) ? (pp_wide << vds_pkg::HALF_W) : pp_wide;

  // Candidate t = q + 2^b gives t^2*P = q^2*P + (q*P << (b+1)) + (P << 2b).
  assign p_big    = vds_pkg::BIG_W'(prod_p_r);
  assign l_big    = vds_pkg::BIG_W'(prod_l_r) << (2 * vds_pkg::COS_QW);
  assign sh_s     = vds_pkg::SH_W'(bit_r) + vds_pkg::SH_W'(1);
  assign sh_p     = vds_pkg::SH_W'(bit_r) << 1;
  assign cand_nxt = r_r + (s_r << sh_s) + (p_big << sh_p);

  assign busy = (st_r != vds_pkg::CS_IDLE);
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= vds_pkg::CS_IDLE;
      pp_vld_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pp_vld_r <= (st_r == vds_pkg::CS_MUL);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vds_pkg::CS_IDLE: begin
        if (start) st_nxt = vds_pkg::CS_MUL;
      end
      vds_pkg::CS_MUL: begin
        if (idx_r == vds_pkg::IDX_LAST) st_nxt = vds_pkg::CS_DRAIN;
      end
      vds_pkg::CS_DRAIN: st_nxt = vds_pkg::CS_CAND;
      vds_pkg::CS_CAND:  st_nxt = vds_pkg::CS_CMP;
      vds_pkg::CS_CMP: begin
        st_nxt = (bit_r == '0) ? vds_pkg::CS_IDLE : vds_pkg::CS_CAND;
      end
      default: st_nxt = vds_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && (st_r == vds_pkg::CS_IDLE)) begin
      xy_r     <= xy_mag;
      xx_r     <= xx_op;
      yy_r     <= yy_op;
      idx_r    <= '0;
      prod_p_r <= '0;
      prod_l_r <= '0;
      r_r      <= '0;
      s_r      <= '0;
      q_r      <= '0;
      bit_r    <= vds_pkg::BIT_W'(vds_pkg::COS_QW - 1);
    end else begin
      if (st_r == vds_pkg::CS_MUL) begin
        pp_r     <= pp_nxt;
        pp_sh_r  <= {1'b0, idx_r[0]} + {1'b0, idx_r[1]};
        pp_dst_r <= idx_r[2];
        idx_r    <= idx_r + vds_pkg::IDX_W'(1);
      end
      if (pp_vld_r) begin
        if (pp_dst_r) begin
          prod_l_r <= prod_l_r + pp_add;
        end else begin
          prod_p_r <= prod_p_r + pp_add;
        end
      end
      if (st_r == vds_pkg::CS_CAND) begin
        cand_r <= cand_nxt;
      end
      if (st_r == vds_pkg::CS_CMP) begin
        if (cand_r <= l_big) begin
          r_r        <= cand_r;
          s_r        <= s_r + (p_big << bit_r);
          q_r[bit_r] <= 1'b1;
        end
        if (bit_r != '0) bit_r <= bit_r - vds_pkg::BIT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/vds_dp.sv
// Datapath: mode register, product stage, saturating accumulators, cosine unit and output register.
`timescale 1ns / 1ps

module vds_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vds_pkg::vds_cmd_t                     cmd,
  output vds_pkg::vds_sts_t                     sts,
  input  logic                                  cfg_wr_en,
  input  logic [vds_pkg::MODE_W-1:0]            cfg_wr_data,
  input  logic signed [vds_pkg::ELEM_WIDTH-1:0] in_x_elem,
  input  logic signed [vds_pkg::ELEM_WIDTH-1:0] in_y_elem,
  output logic signed [vds_pkg::VALUE_W-1:0]    out_value,
  output logic                                  out_overflow
);

  vds_pkg::vds_mode_t mode_r;

  logic signed [vds_pkg::MAG_W-1:0] x_ext, y_ext, d_ext;
  logic [vds_pkg::MAG_W-1:0]        mag_x, mag_y, mag_d, mul_a, mul_b;
  logic [vds_pkg::PROD_W-1:0]       prod_main, prod_xx, prod_yy, term_main;
  logic                             term_neg;

  logic [vds_pkg::PROD_W-1:0] t_main_r, t_xx_r, t_yy_r;
  logic                       t_neg_r, t_cos_r, t_vld_r;

  logic signed [vds_pkg::ACC_WIDTH-1:0] main_sum_r, x_sum_r, y_sum_r;
  logic                                 sat_r;
  vds_pkg::vds_sat_t                    main_add, x_add, y_add;

  logic signed [vds_pkg::ACC_WIDTH-1:0] half_sum;
  logic [vds_pkg::ACC_WIDTH-1:0]        xy_mag, xx_op, yy_op;
  logic                                 cos_busy;
  logic [vds_pkg::COS_QW-1:0]           cos_q;
  logic signed [vds_pkg::COS_QW:0]      q_ext, q_signed;
  logic                                 cos_neg_r, ovf_hold_r;

  logic signed [vds_pkg::VALUE_W-1:0] out_value_r;
  logic                               out_ovf_r;

  assign x_ext = vds_pkg::MAG_W'(in_x_elem);
  assign y_ext = vds_pkg::MAG_W'(in_y_elem);
  assign d_ext = x_ext - y_ext;
  assign mag_x = x_ext[vds_pkg::MAG_W-1] ? -x_ext : x_ext;
  assign mag_y = y_ext[vds_pkg::MAG_W-1] ? -y_ext : y_ext;
  assign mag_d = d_ext[vds_pkg::MAG_W-1] ? -d_ext : d_ext;

  assign mul_a     = (mode_r == vds_pkg::MODE_L2H) ? mag_d : mag_x;
  assign mul_b     = (mode_r == vds_pkg::MODE_L2H) ? mag_d : mag_y;
  assign prod_main = vds_pkg::PROD_W'(mul_a) * vds_pkg::PROD_W'(mul_b);
  assign prod_xx   = vds_pkg::PROD_W'(mag_x) * vds_pkg::PROD_W'(mag_x);
  assign prod_yy   = vds_pkg::PROD_W'(mag_y) * vds_pkg::PROD_W'(mag_y);
  assign term_main = (mode_r == vds_pkg::MODE_L1) ? vds_pkg::PROD_W'(mag_d) : prod_main;
  assign term_neg  = ((mode_r == vds_pkg::MODE_DOT) || (mode_r == vds_pkg::MODE_COS)) &&
                     (in_x_elem[vds_pkg::ELEM_WIDTH-1] ^ in_y_elem[vds_pkg::ELEM_WIDTH-1]);

  assign main_add = vds_pkg::sat_add(main_sum_r, t_neg_r, t_main_r);
  assign x_add    = vds_pkg::sat_add(x_sum_r, 1'b0, t_xx_r);
  assign y_add    = vds_pkg::sat_add(y_sum_r, 1'b0, t_yy_r);

  // Halving rounds toward zero, so a negative sum gets one added before the shift.
  assign half_sum = (main_sum_r +
                     $signed(vds_pkg::ACC_WIDTH'(main_sum_r[vds_pkg::ACC_WIDTH-1]))) >>> 1;

  assign xy_mag = main_sum_r[vds_pkg::ACC_WIDTH-1] ? -main_sum_r : main_sum_r;
  assign xx_op  = (x_sum_r == '0) ? vds_pkg::ACC_WIDTH'(1) : x_sum_r;
  assign yy_op  = (y_sum_r == '0) ? vds_pkg::ACC_WIDTH'(1) : y_sum_r;

  assign q_ext    = {1'b0, cos_q};
  assign q_signed = cos_neg_r ? -q_ext : q_ext;

  assign sts.mode_cos = (mode_r == vds_pkg::MODE_COS);
  assign sts.cos_busy = cos_busy;

  assign out_value    = out_value_r;
  assign out_overflow = out_ovf_r;

  vds_cos u_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.cos_start),
    .xy_mag (xy_mag),
    .xx_op  (xx_op),
    .yy_op  (yy_op),
    .busy   (cos_busy),
    .q      (cos_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= vds_pkg::MODE_L2H;
      t_vld_r    <= 1'b0;
      main_sum_r <= '0;
      x_sum_r    <= '0;
      y_sum_r    <= '0;
      sat_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= vds_pkg::vds_mode_t'(cfg_wr_data);
      t_vld_r <= cmd.accept;
      if (cmd.clear) begin
        main_sum_r <= '0;
        x_sum_r    <= '0;
        y_sum_r    <= '0;
        sat_r      <= 1'b0;
      end else if (t_vld_r) begin
        main_sum_r <= main_add.val;
        if (t_cos_r) begin
          x_sum_r <= x_add.val;
          y_sum_r <= y_add.val;
          sat_r   <= sat_r | main_add.sat | x_add.sat | y_add.sat;
        end else begin
          sat_r <= sat_r | main_add.sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_main_r <= term_main;
      t_xx_r   <= prod_xx;
      t_yy_r   <= prod_yy;
      t_neg_r  <= term_neg;
      t_cos_r  <= (mode_r == vds_pkg::MODE_COS);
    end
    if (cmd.cos_start) begin
      cos_neg_r  <= main_sum_r[vds_pkg::ACC_WIDTH-1];
      ovf_hold_r <= sat_r;
    end
    if (cmd.load_direct) begin
      out_value_r <= (mode_r == vds_pkg::MODE_L2H) ? vds_pkg::VALUE_W'(half_sum)
                                                   : vds_pkg::VALUE_W'(main_sum_r);
      out_ovf_r   <= sat_r;
    end else if (cmd.load_cos) begin
      out_value_r <= vds_pkg::VALUE_W'(q_signed);
      out_ovf_r   <= ovf_hold_r;
    end
  end

endmodule

### hw/rtl/vds_ctrl.sv
// Controller state machine: input acceptance, finishing sequence and output valid.
`timescale 1ns / 1ps

module vds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_elem,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  vds_pkg::vds_sts_t sts,
  output vds_pkg::vds_cmd_t cmd
);

  vds_pkg::vds_state_t st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vds_pkg::ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_stall = 1'b1;
    case (st_r)
      vds_pkg::ST_ACC: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_last_elem) st_nxt = vds_pkg::ST_DRAIN;
      end
      vds_pkg::ST_DRAIN: st_nxt = vds_pkg::ST_FIN;
      vds_pkg::ST_FIN: begin
        if (sts.mode_cos) begin
          cmd.cos_start = 1'b1;
          cmd.clear     = 1'b1;
          st_nxt        = vds_pkg::ST_COS;
        end else if (out_free) begin
          cmd.load_direct = 1'b1;
          cmd.clear       = 1'b1;
          st_nxt          = vds_pkg::ST_ACC;
        end
      end
      vds_pkg::ST_COS: begin
        if (!sts.cos_busy && out_free) begin
          cmd.load_cos = 1'b1;
          st_nxt       = vds_pkg::ST_ACC;
        end
      end
      default: st_nxt = vds_pkg::ST_ACC;
    endcase
    if (cmd.load_direct || cmd.load_cos) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule
